// File: hw/rtl/midi_track_event_parser_assert.svh
// Assertion macros used by the track event parser top level.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hw/rtl/mtep_pkg.sv
// Types, constants and decode functions for the MIDI track event parser.
// No dependencies; used by every other RTL file of the block but the assertion header.
`default_nettype none

package mtep_pkg;

	localparam int DATA_W = 8;
	localparam int LEN_W  = 28;
	localparam int KIND_W = 5;
	localparam int QCNT_W = 3;

	typedef enum logic [7:0] {
		PH_DELTA     = 8'b0000_0001,
		PH_STATUS    = 8'b0000_0010,
		PH_META_TYPE = 8'b0000_0100,
		PH_META_LEN  = 8'b0000_1000,
		PH_SYSEX_LEN = 8'b0001_0000,
		PH_SKIP      = 8'b0010_0000,
		PH_DATA      = 8'b0100_0000,
		PH_HALT      = 8'b1000_0000
	} phase_t;

	localparam logic [KIND_W-1:0] KIND_META_OTHER = 5'd17;
	localparam logic [KIND_W-1:0] KIND_SYSEX_F0   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_SYSEX_F7   = 5'd19;
	localparam logic [KIND_W-1:0] KIND_POLY_PRESS = 5'd20;
	localparam logic [KIND_W-1:0] KIND_CONTROL    = 5'd21;
	localparam logic [KIND_W-1:0] KIND_PROGRAM    = 5'd22;
	localparam logic [KIND_W-1:0] KIND_CHAN_PRESS = 5'd23;
	localparam logic [KIND_W-1:0] KIND_PITCH_BEND = 5'd24;
	localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 5'd25;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 5'd26;
	localparam logic [KIND_W-1:0] KIND_ERROR      = 5'd27;

	localparam logic [DATA_W-1:0] STATUS_META     = 8'hFF;
	localparam logic [DATA_W-1:0] STATUS_SYSEX_F0 = 8'hF0;
	localparam logic [DATA_W-1:0] STATUS_SYSEX_F7 = 8'hF7;

	localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
	localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
	localparam logic [3:0] NIB_CONTROL    = 4'hB;
	localparam logic [3:0] NIB_PROGRAM    = 4'hC;
	localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
	localparam logic [3:0] NIB_PITCH_BEND = 4'hE;
	localparam logic [3:0] NIB_SYSTEM     = 4'hF;

	localparam logic [LEN_W-1:0] CH_LEN_SHORT = 28'd2;
	localparam logic [LEN_W-1:0] CH_LEN_LONG  = 28'd3;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [LEN_W-1:0]  delta_ticks;
		logic [DATA_W-1:0] status_value;
		logic [DATA_W-1:0] meta_code;
		logic [LEN_W-1:0]  payload_length;
		logic [DATA_W-1:0] first_data;
		logic [DATA_W-1:0] second_data;
		logic              track_has_note;
	} result_t;

	// Meta type byte to event kind: 00..09 map straight through.
	function automatic logic [KIND_W-1:0] meta_kind(input logic [DATA_W-1:0] t);
		logic [KIND_W-1:0] k;
		priority if (t <= 8'h09) begin
			k = t[KIND_W-1:0];
		end else begin
			unique case (t)
				8'h20:   k = 5'd10;
				8'h21:   k = 5'd11;
				8'h2F:   k = 5'd12;
				8'h51:   k = 5'd13;
				8'h58:   k = 5'd14;
				8'h59:   k = 5'd15;
				8'h7F:   k = 5'd16;
				default: k = KIND_META_OTHER;
			endcase
		end
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] channel_kind(input logic [3:0] hi);
		logic [KIND_W-1:0] k;
		unique case (hi)
			NIB_NOTE_OFF:   k = KIND_NOTE_OFF;
			NIB_NOTE_ON:    k = KIND_NOTE_ON;
			NIB_POLY_PRESS: k = KIND_POLY_PRESS;
			NIB_CONTROL:    k = KIND_CONTROL;
			NIB_PROGRAM:    k = KIND_PROGRAM;
			NIB_CHAN_PRESS: k = KIND_CHAN_PRESS;
			NIB_PITCH_BEND: k = KIND_PITCH_BEND;
			default:        k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mtep_byte_if.sv
// Byte channel into the MIDI track event parser.
// Depends on mtep_pkg for widths.
`default_nettype none

interface mtep_byte_if;
	logic                      valid;
	logic                      ready;
	logic [mtep_pkg::DATA_W-1:0] data_byte;
	logic                      track_start;

	modport source (output valid, output data_byte, output track_start, input ready);
	modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mtep_event_if.sv
// Event descriptor channel out of the MIDI track event parser.
// Depends on mtep_pkg for widths.
`default_nettype none

interface mtep_event_if;
	logic                        valid;
	logic                        ready;
	logic [mtep_pkg::KIND_W-1:0] event_kind;
	logic [mtep_pkg::LEN_W-1:0]  delta_ticks;
	logic [mtep_pkg::DATA_W-1:0] status_value;
	logic [mtep_pkg::DATA_W-1:0] meta_code;
	logic [mtep_pkg::LEN_W-1:0]  payload_length;
	logic [mtep_pkg::DATA_W-1:0] first_data;
	logic [mtep_pkg::DATA_W-1:0] second_data;
	logic                        track_has_note;

	modport source (
		output valid, output event_kind, output delta_ticks, output status_value,
		output meta_code, output payload_length, output first_data,
		output second_data, output track_has_note, input ready
	);
	modport sink (
		input valid, input event_kind, input delta_ticks, input status_value,
		input meta_code, input payload_length, input first_data,
		input second_data, input track_has_note, output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/midi_track_event_parser.sv
// A byte that ends an event gives its descriptor in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the parser state updates once per accepted byte.
// The byte side stalls only while the result register is full and not drained.
// Reset (arst_n low, asynchronous) returns the parser to waiting for a delta time
// and empties the result register; no clearing pass is needed.
// Top level of the MIDI track event parser; depends on mtep_pkg, both channel
// interfaces, mtep_core, mtep_out_stage and the assertion macro header.
`default_nettype none

`include "midi_track_event_parser_assert.svh"

module midi_track_event_parser #(
	parameter int MAX_QUANTITY_BYTES = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mtep_byte_if.sink    bytes,
	mtep_event_if.source events
);

	logic              space;
	logic              accept;
	logic              res_valid;
	mtep_pkg::result_t res;

	assign bytes.ready = space;
	assign accept      = bytes.valid && space;

	mtep_core #(
		.MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (bytes.data_byte),
		.track_start(bytes.track_start),
		.res_valid  (res_valid),
		.res        (res)
	);

	mtep_out_stage u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept && res_valid),
		.res   (res),
		.space (space),
		.events(events)
	);

	`MTEP_ASSERT_IMP(a_stall_only_when_full, !bytes.ready, events.valid && !events.ready, "byte side stalled with room in the result register")
	`MTEP_ASSERT_IMP(a_error_fields_zero, events.valid && events.event_kind == mtep_pkg::KIND_ERROR, events.payload_length == '0 && events.meta_code == '0 && events.first_data == '0, "error descriptor carries data")
	`MTEP_ASSERT_IMP(a_note_flag, events.valid && (events.event_kind == mtep_pkg::KIND_NOTE_ON || events.event_kind == mtep_pkg::KIND_NOTE_OFF), events.track_has_note, "note event without the note flag")
	`MTEP_ASSERT_IMP(a_meta_status, events.valid && events.event_kind <= mtep_pkg::KIND_META_OTHER, events.status_value == mtep_pkg::STATUS_META, "meta kind without an FF status")
	`MTEP_ASSERT_NXT(a_track_start_silent, bytes.valid && bytes.ready && bytes.track_start && (!events.valid || events.ready), !events.valid, "track start byte produced a descriptor")

endmodule

`default_nettype wire

// File: hw/rtl/mtep_core.sv
// Parser state registers and the per-byte next-state and descriptor logic.
// Depends on mtep_pkg.
`default_nettype none

module mtep_core #(
	parameter int MAX_QUANTITY_BYTES = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [mtep_pkg::DATA_W-1:0] data_byte,
	input  wire logic                        track_start,
	output logic                             res_valid,
	output mtep_pkg::result_t                res
);

	localparam logic [mtep_pkg::QCNT_W-1:0] QMAX = mtep_pkg::QCNT_W'(MAX_QUANTITY_BYTES);

	mtep_pkg::phase_t              phase_q, cur_phase, nxt_phase;
	logic [mtep_pkg::LEN_W-1:0]    delta_q, cur_delta, nxt_delta;
	logic [mtep_pkg::QCNT_W-1:0]   qcnt_q, cur_qcnt, nxt_qcnt, qcnt_inc;
	logic [mtep_pkg::DATA_W-1:0]   status_q, cur_status, nxt_status;
	logic [mtep_pkg::DATA_W-1:0]   meta_q, cur_meta, nxt_meta;
	logic [mtep_pkg::DATA_W-1:0]   first_q, cur_first, nxt_first;
	logic [mtep_pkg::LEN_W-1:0]    len_q, cur_len, nxt_len;
	logic                          note_q, cur_note, nxt_note;
	logic [mtep_pkg::LEN_W-1:0]    seen_q, cur_seen, nxt_seen, seen_inc;
	logic [mtep_pkg::LEN_W-1:0]    len_shift;
	logic [3:0]                    hi;
	logic                          q_last;
	logic                          emit, halt;
	logic                          emit_long;

	// A track start clears everything before the byte itself is decoded.
	always_comb begin
		cur_phase  = track_start ? mtep_pkg::PH_DELTA : phase_q;
		cur_delta  = track_start ? '0 : delta_q;
		cur_qcnt   = track_start ? '0 : qcnt_q;
		cur_status = track_start ? '0 : status_q;
		cur_meta   = track_start ? '0 : meta_q;
		cur_first  = track_start ? '0 : first_q;
		cur_len    = track_start ? '0 : len_q;
		cur_note   = track_start ? 1'b0 : note_q;
		cur_seen   = track_start ? '0 : seen_q;
	end

	assign qcnt_inc  = cur_qcnt + 1'b1;
	assign q_last    = !data_byte[7] || (qcnt_inc >= QMAX);
	assign seen_inc  = cur_seen + 1'b1;
	assign len_shift = {cur_len[mtep_pkg::LEN_W-8:0], data_byte[6:0]};
	assign hi        = cur_status[7:4];

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_delta  = cur_delta;
		nxt_qcnt   = cur_qcnt;
		nxt_status = cur_status;
		nxt_meta   = cur_meta;
		nxt_first  = cur_first;
		nxt_len    = cur_len;
		nxt_note   = cur_note;
		nxt_seen   = cur_seen;
		emit       = 1'b0;
		emit_long  = 1'b0;
		halt       = 1'b0;
		res        = '0;

		unique case (cur_phase)
			mtep_pkg::PH_DELTA: begin
				nxt_delta = {cur_delta[mtep_pkg::LEN_W-8:0], data_byte[6:0]};
				nxt_qcnt  = qcnt_inc;
				if (q_last) begin
					nxt_phase = mtep_pkg::PH_STATUS;
					nxt_qcnt  = '0;
				end
			end
			mtep_pkg::PH_STATUS: begin
				nxt_status = data_byte;
				priority if (data_byte == mtep_pkg::STATUS_META) begin
					nxt_phase = mtep_pkg::PH_META_TYPE;
				end else if (data_byte == mtep_pkg::STATUS_SYSEX_F0 ||
						data_byte == mtep_pkg::STATUS_SYSEX_F7) begin
					nxt_len   = '0;
					nxt_qcnt  = '0;
					nxt_phase = mtep_pkg::PH_SYSEX_LEN;
				end else if (data_byte[7] && data_byte[7:4] != mtep_pkg::NIB_SYSTEM) begin
					if (data_byte[7:4] == mtep_pkg::NIB_NOTE_OFF ||
							data_byte[7:4] == mtep_pkg::NIB_NOTE_ON) begin
						nxt_note = 1'b1;
					end
					nxt_qcnt  = '0;
					nxt_phase = mtep_pkg::PH_DATA;
				end else begin
					emit               = 1'b1;
					halt               = 1'b1;
					res.event_kind     = mtep_pkg::KIND_ERROR;
					res.status_value   = data_byte;
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				nxt_meta  = data_byte;
				nxt_phase = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				nxt_len = mtep_pkg::LEN_W'(data_byte);
				if (data_byte == '0) begin
					emit_long = 1'b1;
				end else begin
					nxt_seen  = '0;
					nxt_phase = mtep_pkg::PH_SKIP;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				nxt_len  = len_shift;
				nxt_qcnt = qcnt_inc;
				if (q_last) begin
					nxt_qcnt = '0;
					if (len_shift == '0) begin
						emit_long = 1'b1;
					end else begin
						nxt_seen  = '0;
						nxt_phase = mtep_pkg::PH_SKIP;
					end
				end
			end
			mtep_pkg::PH_SKIP: begin
				nxt_seen = seen_inc;
				if (seen_inc >= cur_len) begin
					emit_long = 1'b1;
				end
			end
			mtep_pkg::PH_DATA: begin
				if (hi < mtep_pkg::NIB_NOTE_OFF || hi > mtep_pkg::NIB_PITCH_BEND) begin
					nxt_phase = mtep_pkg::PH_HALT;
				end else if (cur_qcnt == '0) begin
					nxt_first = data_byte;
					nxt_qcnt  = mtep_pkg::QCNT_W'(1);
					if (hi == mtep_pkg::NIB_PROGRAM || hi == mtep_pkg::NIB_CHAN_PRESS) begin
						emit               = 1'b1;
						res.event_kind     = mtep_pkg::channel_kind(hi);
						res.status_value   = cur_status;
						res.payload_length = mtep_pkg::CH_LEN_SHORT;
						res.first_data     = data_byte;
					end
				end else begin
					emit               = 1'b1;
					res.event_kind     = mtep_pkg::channel_kind(hi);
					res.status_value   = cur_status;
					res.payload_length = mtep_pkg::CH_LEN_LONG;
					res.first_data     = cur_first;
					res.second_data    = data_byte;
				end
			end
			default: begin
				// Halted after an undefined status: bytes are dropped.
			end
		endcase

		// Meta and sysex events share one descriptor shape.
		if (emit_long) begin
			emit               = 1'b1;
			res.status_value   = cur_status;
			res.payload_length = nxt_len;
			if (cur_status == mtep_pkg::STATUS_META) begin
				res.event_kind = mtep_pkg::meta_kind(cur_meta);
				res.meta_code  = cur_meta;
			end else if (cur_status == mtep_pkg::STATUS_SYSEX_F7) begin
				res.event_kind = mtep_pkg::KIND_SYSEX_F7;
			end else begin
				res.event_kind = mtep_pkg::KIND_SYSEX_F0;
			end
		end

		res.delta_ticks    = cur_delta;
		res.track_has_note = nxt_note;

		if (emit) begin
			nxt_delta = '0;
			nxt_qcnt  = '0;
			nxt_phase = halt ? mtep_pkg::PH_HALT : mtep_pkg::PH_DELTA;
		end
	end

	assign res_valid = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mtep_pkg::PH_DELTA;
			delta_q  <= '0;
			qcnt_q   <= '0;
			status_q <= '0;
			meta_q   <= '0;
			first_q  <= '0;
			len_q    <= '0;
			note_q   <= 1'b0;
			seen_q   <= '0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			delta_q  <= nxt_delta;
			qcnt_q   <= nxt_qcnt;
			status_q <= nxt_status;
			meta_q   <= nxt_meta;
			first_q  <= nxt_first;
			len_q    <= nxt_len;
			note_q   <= nxt_note;
			seen_q   <= nxt_seen;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mtep_out_stage.sv
// Result register that drives the event channel and frees the byte side.
// Depends on mtep_pkg and mtep_event_if.
`default_nettype none

module mtep_out_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire mtep_pkg::result_t   res,
	output logic                     space,
	mtep_event_if.source             events
);

	logic              valid_q;
	mtep_pkg::result_t res_q;

	// The register can take a new descriptor when empty or being drained.
	assign space = !valid_q || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			res_q <= res;
		end
	end

	assign events.valid          = valid_q;
	assign events.event_kind     = res_q.event_kind;
	assign events.delta_ticks    = res_q.delta_ticks;
	assign events.status_value   = res_q.status_value;
	assign events.meta_code      = res_q.meta_code;
	assign events.payload_length = res_q.payload_length;
	assign events.first_data     = res_q.first_data;
	assign events.second_data    = res_q.second_data;
	assign events.track_has_note = res_q.track_has_note;

endmodule

`default_nettype wire

// File: bench/tb_midi_track_event_parser.sv
`timescale 1ns / 100ps
// Self-checking bench for midi_track_event_parser: drives track body bytes and
// checks every event descriptor against a byte-level parser kept in the bench.
// Depends on mtep_pkg, mtep_byte_if, mtep_event_if and the parser RTL.

module tb_midi_track_event_parser;

	localparam int MAX_QUANTITY_BYTES = 4;
	localparam int RANDOM_ITEMS       = 800;
	localparam int DRAIN_SLACK        = 4;
	localparam int DRAIN_LIMIT        = 20000;
	localparam int HOLD_CYCLES        = 80;

	localparam logic [7:0] META_LAST_NUMBERED = 8'h09;
	localparam logic [7:0] META_CHAN_PREFIX   = 8'h20;
	localparam logic [7:0] META_PORT          = 8'h21;
	localparam logic [7:0] META_END_OF_TRACK  = 8'h2F;
	localparam logic [7:0] META_TEMPO         = 8'h51;
	localparam logic [7:0] META_TIME_SIG      = 8'h58;
	localparam logic [7:0] META_KEY_SIG       = 8'h59;
	localparam logic [7:0] META_SEQ_SPECIFIC  = 8'h7F;

	localparam logic [mtep_pkg::KIND_W-1:0] KIND_CHAN_PREFIX  = 5'd10;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_PORT         = 5'd11;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_END_OF_TRACK = 5'd12;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_TEMPO        = 5'd13;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_TIME_SIG     = 5'd14;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_KEY_SIG      = 5'd15;
	localparam logic [mtep_pkg::KIND_W-1:0] KIND_SEQ_SPECIFIC = 5'd16;

	logic clk = 1'b0;
	logic arst_n;

	mtep_byte_if  byte_ch ();
	mtep_event_if event_ch ();

	midi_track_event_parser #(
		.MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.events (event_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Parser state mirrored by the bench.
	mtep_pkg::phase_t           trk_phase;
	logic [mtep_pkg::LEN_W-1:0] trk_delta;
	logic [2:0]                 trk_qcount;
	logic [7:0]                 trk_status;
	logic [7:0]                 trk_meta;
	logic [7:0]                 trk_first;
	logic [mtep_pkg::LEN_W-1:0] trk_len;
	logic [mtep_pkg::LEN_W-1:0] trk_skipped;
	logic                       trk_note;

	mtep_pkg::result_t pending_descriptors[$];

	int fail_count    = 0;
	int bytes_counted = 0;
	int hold_request  = 0;
	bit src_idle_en   = 1'b1;
	bit sink_idle_en  = 1'b1;
	bit start_pending = 1'b0;

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 60) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	function automatic logic [mtep_pkg::KIND_W-1:0] meta_event_kind(input logic [7:0] t);
		if (t <= META_LAST_NUMBERED) begin
			return t[mtep_pkg::KIND_W-1:0];
		end
		case (t)
			META_CHAN_PREFIX:  return KIND_CHAN_PREFIX;
			META_PORT:         return KIND_PORT;
			META_END_OF_TRACK: return KIND_END_OF_TRACK;
			META_TEMPO:        return KIND_TEMPO;
			META_TIME_SIG:     return KIND_TIME_SIG;
			META_KEY_SIG:      return KIND_KEY_SIG;
			META_SEQ_SPECIFIC: return KIND_SEQ_SPECIFIC;
			default:           return mtep_pkg::KIND_META_OTHER;
		endcase
	endfunction

	function automatic logic [mtep_pkg::KIND_W-1:0] channel_event_kind(input logic [3:0] nib);
		case (nib)
			mtep_pkg::NIB_NOTE_OFF:   return mtep_pkg::KIND_NOTE_OFF;
			mtep_pkg::NIB_NOTE_ON:    return mtep_pkg::KIND_NOTE_ON;
			mtep_pkg::NIB_POLY_PRESS: return mtep_pkg::KIND_POLY_PRESS;
			mtep_pkg::NIB_CONTROL:    return mtep_pkg::KIND_CONTROL;
			mtep_pkg::NIB_PROGRAM:    return mtep_pkg::KIND_PROGRAM;
			mtep_pkg::NIB_CHAN_PRESS: return mtep_pkg::KIND_CHAN_PRESS;
			mtep_pkg::NIB_PITCH_BEND: return mtep_pkg::KIND_PITCH_BEND;
			default:                  return mtep_pkg::KIND_ERROR;
		endcase
	endfunction

	task automatic clear_parser();
		trk_phase   = mtep_pkg::PH_DELTA;
		trk_delta   = '0;
		trk_qcount  = '0;
		trk_status  = '0;
		trk_meta    = '0;
		trk_first   = '0;
		trk_len     = '0;
		trk_skipped = '0;
		trk_note    = 1'b0;
	endtask

	// Every descriptor carries the pending delta and restarts delta decoding.
	task automatic queue_descriptor(input logic [mtep_pkg::KIND_W-1:0] kind,
			input logic [7:0] status, input logic [7:0] meta,
			input logic [mtep_pkg::LEN_W-1:0] len,
			input logic [7:0] d1, input logic [7:0] d2);
		mtep_pkg::result_t d;
		d.event_kind     = kind;
		d.delta_ticks    = trk_delta;
		d.status_value   = status;
		d.meta_code      = meta;
		d.payload_length = len;
		d.first_data     = d1;
		d.second_data    = d2;
		d.track_has_note = trk_note;
		pending_descriptors.push_back(d);
		trk_delta  = '0;
		trk_qcount = '0;
		trk_phase  = mtep_pkg::PH_DELTA;
	endtask

	task automatic queue_long_descriptor();
		if (trk_status == mtep_pkg::STATUS_META) begin
			queue_descriptor(meta_event_kind(trk_meta), trk_status, trk_meta, trk_len, 8'h00,
				8'h00);
		end else begin
			queue_descriptor((trk_status == mtep_pkg::STATUS_SYSEX_F7) ?
				mtep_pkg::KIND_SYSEX_F7 : mtep_pkg::KIND_SYSEX_F0,
				trk_status, 8'h00, trk_len, 8'h00, 8'h00);
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic ts);
		logic [3:0] nib;
		logic       last;
		if (ts) begin
			clear_parser();
		end
		case (trk_phase)
			mtep_pkg::PH_DELTA: begin
				trk_delta = {trk_delta[mtep_pkg::LEN_W-8:0], b[6:0]};
				trk_qcount++;
				if (!b[7] || trk_qcount >= MAX_QUANTITY_BYTES) begin
					trk_phase  = mtep_pkg::PH_STATUS;
					trk_qcount = '0;
				end
			end
			mtep_pkg::PH_STATUS: begin
				trk_status = b;
				nib = b[7:4];
				if (b == mtep_pkg::STATUS_META) begin
					trk_phase = mtep_pkg::PH_META_TYPE;
				end else if (b == mtep_pkg::STATUS_SYSEX_F0 ||
						b == mtep_pkg::STATUS_SYSEX_F7) begin
					trk_len    = '0;
					trk_qcount = '0;
					trk_phase  = mtep_pkg::PH_SYSEX_LEN;
				end else if (b[7] && nib != mtep_pkg::NIB_SYSTEM) begin
					if (nib == mtep_pkg::NIB_NOTE_OFF || nib == mtep_pkg::NIB_NOTE_ON) begin
						trk_note = 1'b1;
					end
					trk_qcount = '0;
					trk_phase  = mtep_pkg::PH_DATA;
				end else begin
					// Undefined status: report it, then ignore bytes until a new track.
					queue_descriptor(mtep_pkg::KIND_ERROR, b, 8'h00, '0, 8'h00, 8'h00);
					trk_phase = mtep_pkg::PH_HALT;
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				trk_meta  = b;
				trk_phase = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				trk_len = {{(mtep_pkg::LEN_W-8){1'b0}}, b};
				if (b == 8'h00) begin
					queue_long_descriptor();
				end else begin
					trk_skipped = '0;
					trk_phase   = mtep_pkg::PH_SKIP;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				trk_len = {trk_len[mtep_pkg::LEN_W-8:0], b[6:0]};
				trk_qcount++;
				last = !b[7] || trk_qcount >= MAX_QUANTITY_BYTES;
				if (last) begin
					trk_qcount = '0;
					if (trk_len == '0) begin
						queue_long_descriptor();
					end else begin
						trk_skipped = '0;
						trk_phase   = mtep_pkg::PH_SKIP;
					end
				end
			end
			mtep_pkg::PH_SKIP: begin
				trk_skipped = trk_skipped + 1'b1;
				if (trk_skipped >= trk_len) begin
					queue_long_descriptor();
				end
			end
			mtep_pkg::PH_DATA: begin
				nib = trk_status[7:4];
				if (trk_qcount == '0) begin
					trk_first  = b;
					trk_qcount = 3'd1;
					if (nib == mtep_pkg::NIB_PROGRAM || nib == mtep_pkg::NIB_CHAN_PRESS) begin
						queue_descriptor(channel_event_kind(nib), trk_status, 8'h00,
							mtep_pkg::CH_LEN_SHORT, b, 8'h00);
					end
				end else begin
					queue_descriptor(channel_event_kind(nib), trk_status, 8'h00,
						mtep_pkg::CH_LEN_LONG, trk_first, b);
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// Offers one byte and returns at the edge where the request is taken.
	// valid stays high so that a following byte can go out back to back.
	task automatic send_byte(input logic [7:0] b);
		int   gap;
		logic ts;
		gap = pick_gap(src_idle_en);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ts = start_pending;
		start_pending = 1'b0;
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.track_start <= ts;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		if (!(trk_phase == mtep_pkg::PH_HALT && !ts)) begin
			bytes_counted++;
		end
		predict_byte(b, ts);
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (pending_descriptors.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic begin_track();
		start_pending = 1'b1;
	endtask

	// Variable-length quantity, most significant group first. An over-long one
	// keeps bit 7 set on its last byte too.
	task automatic put_quantity(input logic [mtep_pkg::LEN_W-1:0] v, input int n,
			input bit overlong);
		logic [7:0] b;
		for (int i = n - 1; i >= 0; i--) begin
			b = {(i > 0) || overlong, v[7*i +: 7]};
			send_byte(b);
		end
	endtask

	task automatic put_random_delta();
		int                         n;
		logic [mtep_pkg::LEN_W-1:0] v;
		n = $urandom_range(1, 4);
		v = mtep_pkg::LEN_W'($urandom);
		if (n < 4) begin
			v = v & ((28'd1 << (7 * n)) - 1'b1);
		end
		put_quantity(v, n, n == 4 && $urandom_range(0, 9) == 0);
	endtask

	task automatic send_channel(input logic [7:0] status, input logic [7:0] d1,
			input logic [7:0] d2);
		send_byte(status);
		send_byte(d1);
		if (status[7:4] != mtep_pkg::NIB_PROGRAM && status[7:4] != mtep_pkg::NIB_CHAN_PRESS) begin
			send_byte(d2);
		end
	endtask

	task automatic send_meta(input logic [7:0] mtype, input logic [7:0] mlen);
		send_byte(mtep_pkg::STATUS_META);
		send_byte(mtype);
		send_byte(mlen);
		repeat (mlen) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_sysex(input logic [7:0] status, input logic [mtep_pkg::LEN_W-1:0] slen,
			input int lbytes, input bit overlong);
		send_byte(status);
		put_quantity(slen, lbytes, overlong);
		repeat (slen) send_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] random_bad_status();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range(8'h00, 8'h7F));
			1:       return 8'($urandom_range(8'hF1, 8'hF6));
			default: return 8'($urandom_range(8'hF8, 8'hFE));
		endcase
	endfunction

	function automatic logic [7:0] random_meta_type();
		int k;
		if ($urandom_range(0, 9) < 3) begin
			return 8'($urandom_range(0, 255));
		end
		k = $urandom_range(0, 16);
		case (k)
			10:      return META_CHAN_PREFIX;
			11:      return META_PORT;
			12:      return META_END_OF_TRACK;
			13:      return META_TEMPO;
			14:      return META_TIME_SIG;
			15:      return META_KEY_SIG;
			16:      return META_SEQ_SPECIFIC;
			default: return k[7:0];
		endcase
	endfunction

	// Descriptor checker: compares each accepted descriptor with the oldest prediction.
	always @(posedge clk) begin
		mtep_pkg::result_t got;
		mtep_pkg::result_t want;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			got.event_kind     = event_ch.event_kind;
			got.delta_ticks    = event_ch.delta_ticks;
			got.status_value   = event_ch.status_value;
			got.meta_code      = event_ch.meta_code;
			got.payload_length = event_ch.payload_length;
			got.first_data     = event_ch.first_data;
			got.second_data    = event_ch.second_data;
			got.track_has_note = event_ch.track_has_note;
			if (pending_descriptors.size() == 0) begin
				report_fail($sformatf("descriptor with none predicted: kind %0d status %02h",
					got.event_kind, got.status_value));
			end else begin
				want = pending_descriptors.pop_front();
				if (got.event_kind !== want.event_kind)
					report_fail($sformatf("event_kind %0d, predicted %0d",
						got.event_kind, want.event_kind));
				if (got.delta_ticks !== want.delta_ticks)
					report_fail($sformatf("delta_ticks %0h, predicted %0h",
						got.delta_ticks, want.delta_ticks));
				if (got.status_value !== want.status_value)
					report_fail($sformatf("status_value %02h, predicted %02h",
						got.status_value, want.status_value));
				if (got.meta_code !== want.meta_code)
					report_fail($sformatf("meta_code %02h, predicted %02h",
						got.meta_code, want.meta_code));
				if (got.payload_length !== want.payload_length)
					report_fail($sformatf("payload_length %0d, predicted %0d",
						got.payload_length, want.payload_length));
				if (got.first_data !== want.first_data)
					report_fail($sformatf("first_data %02h, predicted %02h",
						got.first_data, want.first_data));
				if (got.second_data !== want.second_data)
					report_fail($sformatf("second_data %02h, predicted %02h",
						got.second_data, want.second_data));
				if (got.track_has_note !== want.track_has_note)
					report_fail($sformatf("track_has_note %0b, predicted %0b",
						got.track_has_note, want.track_has_note));
			end
		end
	end

	// Descriptor side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int stall_left;
		stall_left = 0;
		event_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0) begin
				stall_left = pick_gap(sink_idle_en);
			end
			if (stall_left > 0) begin
				event_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_channel_messages();
		begin_track();
		put_quantity(28'd0, 1, 1'b0);
		send_channel({mtep_pkg::NIB_NOTE_OFF, 4'h0}, 8'h00, 8'hFF);
		put_quantity(28'd1, 1, 1'b0);
		send_channel({mtep_pkg::NIB_NOTE_ON, 4'hF}, 8'hFF, 8'h00);
		put_quantity(28'd127, 1, 1'b0);
		send_channel({mtep_pkg::NIB_POLY_PRESS, 4'h5}, 8'h7F, 8'h80);
		put_quantity(28'd128, 2, 1'b0);
		send_channel({mtep_pkg::NIB_CONTROL, 4'hA}, 8'h80, 8'h7F);
		put_quantity(28'd0, 1, 1'b0);
		send_channel({mtep_pkg::NIB_PROGRAM, 4'h0}, 8'hFF, 8'h00);
		put_quantity(28'd3, 1, 1'b0);
		send_channel({mtep_pkg::NIB_CHAN_PRESS, 4'hF}, 8'h00, 8'h00);
		put_quantity(28'd9, 1, 1'b0);
		send_channel({mtep_pkg::NIB_PITCH_BEND, 4'h3}, 8'h55, 8'hAA);
		wait_drained();
	endtask

	task automatic test_meta_events();
		logic [7:0] kinds [0:18];
		kinds = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
			META_CHAN_PREFIX, META_PORT, META_END_OF_TRACK, META_TEMPO, META_TIME_SIG,
			META_KEY_SIG, META_SEQ_SPECIFIC, 8'h0A, 8'hFF};
		begin_track();
		for (int i = 0; i < 19; i++) begin
			put_quantity(28'(i), 1, 1'b0);
			send_meta(kinds[i], 8'(i % 4));
		end
		put_quantity(28'd0, 1, 1'b0);
		send_meta(8'h7E, 8'hFF);
		wait_drained();
	endtask

	task automatic test_sysex();
		begin_track();
		put_quantity(28'd0, 1, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F0, 28'd0, 1, 1'b0);
		put_quantity(28'd2, 1, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F7, 28'd3, 1, 1'b0);
		// Padded length: three leading zero groups.
		put_quantity(28'd0, 1, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F0, 28'd5, 4, 1'b0);
		// Over-long length ends at its fourth byte anyway.
		put_quantity(28'd1, 1, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F7, 28'd2, 4, 1'b1);
		put_quantity(28'd1, 1, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F0, 28'd0, 4, 1'b1);
		wait_drained();
	endtask

	task automatic test_delta_extremes();
		begin_track();
		put_quantity(28'h0FFFFFFF, 4, 1'b0);
		send_channel({mtep_pkg::NIB_NOTE_ON, 4'h1}, 8'h3C, 8'h40);
		put_quantity(28'h0FFFFFFF, 4, 1'b1);
		send_meta(META_TEMPO, 8'd3);
		put_quantity(28'h0000001, 4, 1'b1);
		send_channel({mtep_pkg::NIB_PROGRAM, 4'h2}, 8'h10, 8'h00);
		put_quantity(28'h0200000, 4, 1'b0);
		send_sysex(mtep_pkg::STATUS_SYSEX_F0, 28'd1, 1, 1'b0);
		wait_drained();
	endtask

	task automatic test_undefined_status();
		logic [7:0] bad [0:4];
		bad = '{8'h00, 8'h7F, 8'hF1, 8'hF8, 8'hFE};
		for (int i = 0; i < 5; i++) begin
			begin_track();
			if (i == 0) begin
				put_quantity(28'd4, 1, 1'b0);
				send_channel({mtep_pkg::NIB_NOTE_OFF, 4'h9}, 8'h40, 8'h00);
			end
			put_quantity(28'(i * 100), 2, 1'b0);
			send_byte(bad[i]);
			// These must all be ignored until the next track starts.
			send_byte(mtep_pkg::STATUS_META);
			send_byte({mtep_pkg::NIB_NOTE_ON, 4'h0});
			send_byte(8'h00);
		end
		begin_track();
		put_quantity(28'd0, 1, 1'b0);
		send_meta(META_END_OF_TRACK, 8'd0);
		wait_drained();
	endtask

	task automatic test_track_restart();
		begin_track();
		put_quantity(28'd5, 1, 1'b0);
		send_byte(mtep_pkg::STATUS_SYSEX_F0);
		put_quantity(28'h0FFFFFFF, 4, 1'b0);
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		begin_track();
		put_quantity(28'd6, 1, 1'b0);
		send_byte(mtep_pkg::STATUS_META);
		send_byte(META_TEMPO);
		begin_track();
		put_quantity(28'd7, 1, 1'b0);
		send_byte({mtep_pkg::NIB_NOTE_ON, 4'h2});
		send_byte(8'h3C);
		begin_track();
		send_byte(8'h81);
		begin_track();
		put_quantity(28'd8, 1, 1'b0);
		send_channel({mtep_pkg::NIB_CONTROL, 4'h0}, 8'h07, 8'h64);
		wait_drained();
	endtask

	// The descriptor side holds off while bytes keep coming, so the parser backs up.
	task automatic test_backpressure();
		src_idle_en  = 1'b0;
		hold_request = HOLD_CYCLES;
		begin_track();
		for (int i = 0; i < 30; i++) begin
			put_quantity(28'(i), 1, 1'b0);
			send_channel({mtep_pkg::NIB_PROGRAM, 4'(i)}, 8'(i * 7), 8'h00);
		end
		src_idle_en = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_stream();
		int         start_count;
		int         chunk_end;
		int         r;
		logic [3:0] nib;
		int         lbytes;
		start_count = bytes_counted;
		chunk_end   = 0;
		begin_track();
		while (bytes_counted - start_count < RANDOM_ITEMS) begin
			if (bytes_counted >= chunk_end) begin
				r = $urandom_range(0, 5);
				src_idle_en  = (r != 1 && r != 3);
				sink_idle_en = (r != 2 && r != 3);
				chunk_end    = bytes_counted + 100;
			end
			r = $urandom_range(0, 99);
			if (r < 40) begin
				nib = 4'($urandom_range(8, 14));
				put_random_delta();
				send_channel({nib, 4'($urandom_range(0, 15))}, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else if (r < 58) begin
				put_random_delta();
				send_meta(random_meta_type(),
					($urandom_range(0, 99) < 97) ? 8'($urandom_range(0, 8)) :
					8'($urandom_range(9, 255)));
			end else if (r < 70) begin
				lbytes = $urandom_range(1, 4);
				put_random_delta();
				send_sysex($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX_F7 :
					mtep_pkg::STATUS_SYSEX_F0,
					mtep_pkg::LEN_W'($urandom_range(0, 6)), lbytes,
					lbytes == 4 && $urandom_range(0, 3) == 0);
			end else if (r < 75) begin
				put_random_delta();
				send_byte(random_bad_status());
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
				begin_track();
			end else if (r < 80) begin
				begin_track();
			end else if (r < 86) begin
				// Event cut short by a new track.
				put_random_delta();
				case ($urandom_range(0, 2))
					0:       send_byte(mtep_pkg::STATUS_META);
					1:       send_byte(mtep_pkg::STATUS_SYSEX_F0);
					default: send_byte({mtep_pkg::NIB_NOTE_ON, 4'($urandom_range(0, 15))});
				endcase
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
				begin_track();
			end else if (r < 92) begin
				repeat ($urandom_range(1, 4)) begin
					start_pending = ($urandom_range(0, 15) == 0);
					send_byte(8'($urandom_range(0, 255)));
				end
				begin_track();
			end else begin
				put_random_delta();
				send_meta(META_END_OF_TRACK, 8'd0);
				begin_track();
			end
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	initial begin
		int waited;
		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.data_byte   <= 8'h00;
		byte_ch.track_start <= 1'b0;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_channel_messages();
		test_meta_events();
		test_sysex();
		test_delta_extremes();
		test_undefined_status();
		test_track_restart();
		test_backpressure();
		test_random_stream();
		byte_ch.valid <= 1'b0;
		waited = 0;
		while (pending_descriptors.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_SLACK) @(posedge clk);
		if (pending_descriptors.size() != 0) begin
			report_fail($sformatf("%0d predicted descriptors never arrived",
				pending_descriptors.size()));
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#15000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
